// File: sv/sdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPH density/pressure package
// Shared widths, register indexes and the command/status types that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sdp_pkg;

   localparam int DATA_W      = 32;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = 80;
   localparam int REQ_DATA_W  = 288;
   localparam int RSP_DATA_W  = 64;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS_SQ = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_POLY6     = 1'b1;

   // operand pair fed to the shared multiplier
   typedef enum logic [3:0] {
      MUL_DX,
      MUL_DY,
      MUL_DZ,
      MUL_MP,
      MUL_DD,
      MUL_SQ_LO,
      MUL_SQ_HI,
      MUL_T_LL,
      MUL_T_LH,
      MUL_T_HL,
      MUL_T_HH,
      MUL_PR_LO,
      MUL_PR_HI
   } mul_op_type;

   // squared distance accumulator
   typedef enum logic [1:0] {
      D2_HOLD,
      D2_LOAD,
      D2_ADD
   } d2_op_type;

   // partial product accumulator
   typedef enum logic [1:0] {
      PROD_HOLD,
      PROD_LOAD,
      PROD_ADD32,
      PROD_ADD64
   } prod_op_type;

   // capture of intermediate and final values
   typedef enum logic [3:0] {
      CAP_NONE,
      CAP_RANGE,
      CAP_MP,
      CAP_SQ,
      CAP_CUBE,
      CAP_TERM,
      CAP_RHO,
      CAP_EX,
      CAP_OUT
   } cap_op_type;

   typedef struct packed {
      logic        load;
      mul_op_type  mul_op;
      d2_op_type   d2_op;
      prod_op_type prod_op;
      cap_op_type  cap_op;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// File: sv/sdp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPH density/pressure datapath
// Request latch, one shared 32x32 multiplier with a registered product,
// partial product accumulator, density accumulator, configuration
// registers and the result output register.
// ----------------------------------------------------------------------------
module sdp_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  sdp_pkg::dp_cmd_type              cmd,
   output sdp_pkg::dp_status_type           status,
   input  wire [sdp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                              req_tuser,
   input  wire                              req_tlast,
   input  wire                              csr_valid,
   input  wire [sdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [sdp_pkg::DATA_W-1:0]        csr_wdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [sdp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int DW  = sdp_pkg::DATA_W;
   localparam int AW  = sdp_pkg::ACC_W;
   localparam int PW  = sdp_pkg::PROD_W;
   localparam int D2W = 2 * DW + 2 - FRAC_BITS;
   localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

   // |n - s| of two signed coordinates, always fits 32 bits
   function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] s,
                                              input logic [DW-1:0] n);
      logic [DW:0] d;
      d = {n[DW-1], n} - {s[DW-1], s};
      if (d[DW]) begin
         d = -d;
      end
      return d[DW-1:0];
   endfunction

   logic [DW-1:0]  mag_ff [3];
   logic [DW-1:0]  mass_ff;
   logic [DW-1:0]  rest_ff;
   logic [DW-1:0]  gas_ff;
   logic           self_ff;
   logic           last_ff;
   logic [DW-1:0]  radius_ff;
   logic [DW-1:0]  poly6_ff;
   logic [DW-1:0]  mul_a;
   logic [DW-1:0]  mul_b;
   logic [2*DW-1:0] mul_ff;
   logic [D2W-1:0] d2_ff;
   logic [PW-1:0]  prod_ff;
   logic [PW-1:0]  prod_in;
   logic [PW-1:0]  prod_shift;
   logic [AW-1:0]  prod_sat;
   logic [DW-1:0]  prod_sat32;
   logic [DW-1:0]  diff_ff;
   logic           hit_ff;
   logic [AW-1:0]  mp_ff;
   logic [AW-1:0]  sq_ff;
   logic [AW-1:0]  cube_ff;
   logic [AW-1:0]  acc_ff;
   logic [AW:0]    acc_sum;
   logic [AW-1:0]  rho_ff;
   logic [AW-1:0]  ex_ff;
   logic           rsp_valid_ff;
   logic [sdp_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // latch the request: component magnitudes and per-particle values
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff[0] <= abs_diff(req_tdata[31:0],   req_tdata[127:96]);
         mag_ff[1] <= abs_diff(req_tdata[63:32],  req_tdata[159:128]);
         mag_ff[2] <= abs_diff(req_tdata[95:64],  req_tdata[191:160]);
         mass_ff   <= req_tdata[223:192];
         rest_ff   <= req_tdata[255:224];
         gas_ff    <= req_tdata[287:256];
         self_ff   <= req_tuser;
         last_ff   <= req_tlast;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ONE_Q;
         poly6_ff  <= ONE_Q;
      end else if (csr_valid) begin
         priority if (csr_index == sdp_pkg::REG_RADIUS_SQ) begin
            radius_ff <= csr_wdata;
         end else if (csr_index == sdp_pkg::REG_POLY6) begin
            poly6_ff <= csr_wdata;
         end
      end
   end

   // select multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         sdp_pkg::MUL_DX: begin
            mul_a = mag_ff[0];
            mul_b = mag_ff[0];
         end
         sdp_pkg::MUL_DY: begin
            mul_a = mag_ff[1];
            mul_b = mag_ff[1];
         end
         sdp_pkg::MUL_DZ: begin
            mul_a = mag_ff[2];
            mul_b = mag_ff[2];
         end
         sdp_pkg::MUL_MP: begin
            mul_a = mass_ff;
            mul_b = poly6_ff;
         end
         sdp_pkg::MUL_DD: begin
            mul_a = diff_ff;
            mul_b = diff_ff;
         end
         sdp_pkg::MUL_SQ_LO: begin
            mul_a = sq_ff[DW-1:0];
            mul_b = diff_ff;
         end
         sdp_pkg::MUL_SQ_HI: begin
            mul_a = DW'(sq_ff[AW-1:DW]);
            mul_b = diff_ff;
         end
         sdp_pkg::MUL_T_LL: begin
            mul_a = cube_ff[DW-1:0];
            mul_b = mp_ff[DW-1:0];
         end
         sdp_pkg::MUL_T_LH: begin
            mul_a = cube_ff[DW-1:0];
            mul_b = DW'(mp_ff[AW-1:DW]);
         end
         sdp_pkg::MUL_T_HL: begin
            mul_a = DW'(cube_ff[AW-1:DW]);
            mul_b = mp_ff[DW-1:0];
         end
         sdp_pkg::MUL_T_HH: begin
            mul_a = DW'(cube_ff[AW-1:DW]);
            mul_b = DW'(mp_ff[AW-1:DW]);
         end
         sdp_pkg::MUL_PR_LO: begin
            mul_a = gas_ff;
            mul_b = ex_ff[DW-1:0];
         end
         sdp_pkg::MUL_PR_HI: begin
            mul_a = gas_ff;
            mul_b = DW'(ex_ff[AW-1:DW]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // shared multiplier, product registered
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // sum of the three component squares
   always_ff @(posedge clock) begin
      unique case (cmd.d2_op)
         sdp_pkg::D2_LOAD: d2_ff <= D2W'(mul_ff[2*DW-1:FRAC_BITS]);
         sdp_pkg::D2_ADD:  d2_ff <= d2_ff + D2W'(mul_ff[2*DW-1:FRAC_BITS]);
         default:          d2_ff <= d2_ff;
      endcase
   end

   // gather partial products of a wide multiply
   always_comb begin
      unique case (cmd.prod_op)
         sdp_pkg::PROD_LOAD:  prod_in = PW'(mul_ff);
         sdp_pkg::PROD_ADD32: prod_in = prod_ff + (PW'(mul_ff) << DW);
         sdp_pkg::PROD_ADD64: prod_in = prod_ff + (PW'(mul_ff) << (2 * DW));
         default:             prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // drop fraction bits and saturate the product
   always_comb begin
      prod_shift = prod_ff >> FRAC_BITS;
      prod_sat   = (|prod_shift[PW-1:AW]) ? sdp_pkg::ACC_MAX : prod_shift[AW-1:0];
      prod_sat32 = (|prod_shift[PW-1:DW]) ? {DW{1'b1}} : prod_shift[DW-1:0];
      acc_sum    = {1'b0, acc_ff} + {1'b0, prod_sat};
   end

   // capture intermediate values
   always_ff @(posedge clock) begin
      unique case (cmd.cap_op)
         sdp_pkg::CAP_RANGE: begin
            hit_ff  <= !self_ff && (d2_ff <= D2W'(radius_ff));
            diff_ff <= radius_ff - d2_ff[DW-1:0];
         end
         sdp_pkg::CAP_MP:   mp_ff   <= prod_sat;
         sdp_pkg::CAP_SQ:   sq_ff   <= prod_sat;
         sdp_pkg::CAP_CUBE: cube_ff <= prod_sat;
         sdp_pkg::CAP_RHO:  rho_ff  <= (acc_ff > AW'(rest_ff)) ? acc_ff : AW'(rest_ff);
         sdp_pkg::CAP_EX:   ex_ff   <= rho_ff - AW'(rest_ff);
         default: begin
         end
      endcase
   end

   // density accumulator: add the kernel term, clear after the last neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.cap_op == sdp_pkg::CAP_TERM) begin
         acc_ff <= acc_sum[AW] ? sdp_pkg::ACC_MAX : acc_sum[AW-1:0];
      end else if (cmd.cap_op == sdp_pkg::CAP_RHO) begin
         acc_ff <= '0;
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.cap_op == sdp_pkg::CAP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_op == sdp_pkg::CAP_OUT) begin
         rsp_data_ff <= {prod_sat32,
                         (|rho_ff[AW-1:DW]) ? {DW{1'b1}} : rho_ff[DW-1:0]};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.hit      = hit_ff;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

// File: sv/sdp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPH density/pressure controller
// Sequences one request through the shared multiplier: distance squares,
// range test, kernel cube, kernel term, and on the last neighbor the
// density clamp and pressure product.
// ----------------------------------------------------------------------------
module sdp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  sdp_pkg::dp_status_type status,
   output sdp_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ0,
      S_SQ1,
      S_SQ2,
      S_SQ3,
      S_RANGE,
      S_MP,
      S_DD_SUM,
      S_SQ_CAP,
      S_CB_LO,
      S_CB_HI,
      S_CB_SUM,
      S_CB_CAP,
      S_T_LL,
      S_T_LH,
      S_T_HL,
      S_T_HH,
      S_T_SUM,
      S_ACC,
      S_RHO,
      S_EX,
      S_PR_LO,
      S_PR_HI,
      S_PR_SUM,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      cmd.load    = accept;
      cmd.mul_op  = sdp_pkg::MUL_DX;
      cmd.d2_op   = sdp_pkg::D2_HOLD;
      cmd.prod_op = sdp_pkg::PROD_HOLD;
      cmd.cap_op  = sdp_pkg::CAP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SQ0;
            end
         end
         S_SQ0: begin
            cmd.mul_op = sdp_pkg::MUL_DX;
            state_in   = S_SQ1;
         end
         S_SQ1: begin
            cmd.mul_op = sdp_pkg::MUL_DY;
            cmd.d2_op  = sdp_pkg::D2_LOAD;
            state_in   = S_SQ2;
         end
         S_SQ2: begin
            cmd.mul_op = sdp_pkg::MUL_DZ;
            cmd.d2_op  = sdp_pkg::D2_ADD;
            state_in   = S_SQ3;
         end
         S_SQ3: begin
            cmd.mul_op = sdp_pkg::MUL_MP;
            cmd.d2_op  = sdp_pkg::D2_ADD;
            state_in   = S_RANGE;
         end
         S_RANGE: begin
            cmd.prod_op = sdp_pkg::PROD_LOAD;
            cmd.cap_op  = sdp_pkg::CAP_RANGE;
            state_in    = S_MP;
         end
         S_MP: begin
            cmd.mul_op = sdp_pkg::MUL_DD;
            cmd.cap_op = sdp_pkg::CAP_MP;
            // skip the kernel for self entries and neighbors out of range
            priority if (status.hit) begin
               state_in = S_DD_SUM;
            end else if (status.last) begin
               state_in = S_RHO;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DD_SUM: begin
            cmd.prod_op = sdp_pkg::PROD_LOAD;
            state_in    = S_SQ_CAP;
         end
         S_SQ_CAP: begin
            cmd.cap_op = sdp_pkg::CAP_SQ;
            state_in   = S_CB_LO;
         end
         S_CB_LO: begin
            cmd.mul_op = sdp_pkg::MUL_SQ_LO;
            state_in   = S_CB_HI;
         end
         S_CB_HI: begin
            cmd.mul_op  = sdp_pkg::MUL_SQ_HI;
            cmd.prod_op = sdp_pkg::PROD_LOAD;
            state_in    = S_CB_SUM;
         end
         S_CB_SUM: begin
            cmd.prod_op = sdp_pkg::PROD_ADD32;
            state_in    = S_CB_CAP;
         end
         S_CB_CAP: begin
            cmd.cap_op = sdp_pkg::CAP_CUBE;
            state_in   = S_T_LL;
         end
         S_T_LL: begin
            cmd.mul_op = sdp_pkg::MUL_T_LL;
            state_in   = S_T_LH;
         end
         S_T_LH: begin
            cmd.mul_op  = sdp_pkg::MUL_T_LH;
            cmd.prod_op = sdp_pkg::PROD_LOAD;
            state_in    = S_T_HL;
         end
         S_T_HL: begin
            cmd.mul_op  = sdp_pkg::MUL_T_HL;
            cmd.prod_op = sdp_pkg::PROD_ADD32;
            state_in    = S_T_HH;
         end
         S_T_HH: begin
            cmd.mul_op  = sdp_pkg::MUL_T_HH;
            cmd.prod_op = sdp_pkg::PROD_ADD32;
            state_in    = S_T_SUM;
         end
         S_T_SUM: begin
            cmd.prod_op = sdp_pkg::PROD_ADD64;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.cap_op = sdp_pkg::CAP_TERM;
            state_in   = status.last ? S_RHO : S_IDLE;
         end
         S_RHO: begin
            cmd.cap_op = sdp_pkg::CAP_RHO;
            state_in   = S_EX;
         end
         S_EX: begin
            cmd.cap_op = sdp_pkg::CAP_EX;
            state_in   = S_PR_LO;
         end
         S_PR_LO: begin
            cmd.mul_op = sdp_pkg::MUL_PR_LO;
            state_in   = S_PR_HI;
         end
         S_PR_HI: begin
            cmd.mul_op  = sdp_pkg::MUL_PR_HI;
            cmd.prod_op = sdp_pkg::PROD_LOAD;
            state_in    = S_PR_SUM;
         end
         S_PR_SUM: begin
            cmd.prod_op = sdp_pkg::PROD_ADD32;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.cap_op = sdp_pkg::CAP_OUT;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/sph_density_pressure.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPH density and pressure, poly6 kernel
// Accumulates the poly6 density of one particle over its neighbor requests
// and emits clamped density and pressure on the last neighbor.
// ----------------------------------------------------------------------------
// One neighbor request is taken at a time and all products go through a
// single 32x32 multiplier, so the cost of a request is set by how many
// multiplies it needs: a self entry or a neighbor outside the smoothing
// radius needs fewer than a neighbor inside it, and the request marked last
// adds the density clamp and pressure product (longer if the previous
// result has not yet been taken). A result waits in an output register,
// so the next request is taken while it is pending. Configuration writes
// are always ready and should only be issued while no request is in flight.
module sph_density_pressure #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // self_x, self_y, self_z, nbr_x, nbr_y, nbr_z, nbr_mass, rest_density,
   // gas_const, 32 bits each from bit 0 up
   input  wire  [sdp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // is_self
   input  wire                                 req_tuser,
   // last_nbr
   input  wire                                 req_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // density [31:0], pressure [63:32]
   output logic [sdp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [sdp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [sdp_pkg::DATA_W-1:0]          csr_wdata
);

   sdp_pkg::dp_cmd_type    cmd;
   sdp_pkg::dp_status_type status;

   // configuration registers take a write every cycle
   assign csr_ready = 1'b1;

   sdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: sv/sdp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SPH density/pressure port checker
// Watches the top level ports for stalls, request pacing and reset state.
// ----------------------------------------------------------------------------
module sdp_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [sdp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request at a time: ready drops after each accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // a new result needs the full distance and range sequence first
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid)
         ##1 !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("result appeared too soon after a request");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind sph_density_pressure sdp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPH density and pressure testbench
// Streams neighbor requests through the poly6 density block. A driver and a
// monitor run as clocked processes with random gaps and stalls. A local
// predictor works out density and pressure for every particle and each
// response is checked against it, field by field. The kernel registers are
// reprogrammed between phases while the block is quiet.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAC_BITS       = 16;
   localparam int SETTLE_CYCLES   = 64;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 115;

   localparam int DATA_W      = sdp_pkg::DATA_W;
   localparam int ACC_W       = sdp_pkg::ACC_W;
   localparam int PROD_W      = sdp_pkg::PROD_W;
   localparam int REQ_DATA_W  = sdp_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W  = sdp_pkg::RSP_DATA_W;
   localparam int CSR_INDEX_W = sdp_pkg::CSR_INDEX_W;
   localparam logic [ACC_W-1:0] ACC_MAX = sdp_pkg::ACC_MAX;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_POS = 32'h8000_0000;
   localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;

   // one neighbor request, positions kept as raw two's complement
   typedef struct {
      logic [31:0] self_x, self_y, self_z;
      logic [31:0] nbr_x, nbr_y, nbr_z;
      logic [31:0] nbr_mass, rest_density, gas_const;
      logic        is_self, last_nbr;
   } nbr_req_type;

   typedef struct {
      logic [31:0] density;
      logic [31:0] pressure;
   } rho_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = sdp_pkg::REG_RADIUS_SQ;
   logic [DATA_W-1:0]      csr_wdata  = '0;

   // predictor state: kernel registers and density sum
   logic [31:0]      h2_reg    = Q_ONE;
   logic [31:0]      poly6_reg = Q_ONE;
   logic [ACC_W-1:0] rho_acc   = '0;

   nbr_req_type    nbr_queue[$];
   rho_result_type expected_rho[$];

   nbr_req_type req_cur;
   int       req_gap        = 0;
   bit       req_burst      = 1'b0;
   int       rsp_stall      = 0;
   bit       rsp_burst      = 1'b0;
   int       req_count      = 0;
   int       rsp_count      = 0;
   int       mismatch_count = 0;
   int       setting_count  = 1;

   always #4 clock = ~clock;

   sph_density_pressure #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Q.F product, truncated, saturated to the accumulator width
   function automatic logic [ACC_W-1:0] qmul_sat(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
      logic [PROD_W-1:0] prod;
      prod = (PROD_W'(a) * PROD_W'(b)) >> FRAC_BITS;
      qmul_sat = (prod > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
   endfunction

   // squared axis distance in Q.F; 32-bit positions never differ by 2^32,
   // so the far-component case cannot arise here
   function automatic logic [63:0] axis_sq(logic [31:0] p, logic [31:0] q);
      logic signed [32:0] d;
      logic [32:0]        m;
      logic [65:0]        sq;
      d  = $signed({q[31], q}) - $signed({p[31], p});
      m  = d[32] ? -d : d;
      sq = m * m;
      axis_sq = 64'(sq >> FRAC_BITS);
   endfunction

   // add one neighbor's kernel term; on the last neighbor queue the result
   function automatic void predict_density(nbr_req_type r);
      logic [63:0]      d2;
      logic [ACC_W-1:0] diff, term, rho, prs;
      logic [ACC_W:0]   sum;
      rho_result_type   res;
      d2 = axis_sq(r.self_x, r.nbr_x) + axis_sq(r.self_y, r.nbr_y)
         + axis_sq(r.self_z, r.nbr_z);
      if (!r.is_self && d2 <= 64'(h2_reg)) begin
         diff    = ACC_W'(64'(h2_reg) - d2);
         term    = qmul_sat(qmul_sat(ACC_W'(r.nbr_mass), ACC_W'(poly6_reg)),
                            qmul_sat(qmul_sat(diff, diff), diff));
         sum     = rho_acc + term;
         rho_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
      end
      if (r.last_nbr) begin
         rho = (rho_acc > ACC_W'(r.rest_density)) ? rho_acc : ACC_W'(r.rest_density);
         prs = qmul_sat(ACC_W'(r.gas_const), rho - ACC_W'(r.rest_density));
         res.density  = (rho[ACC_W-1:32] != 0) ? MAX32 : rho[31:0];
         res.pressure = (prs[ACC_W-1:32] != 0) ? MAX32 : prs[31:0];
         expected_rho.push_back(res);
         rho_acc = '0;
      end
   endfunction

   function automatic nbr_req_type neighbor(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                            logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                            logic [31:0] mass, logic [31:0] rest,
                                            logic [31:0] gas, logic self_flag,
                                            logic last_flag);
      nbr_req_type r;
      r.self_x = sx;  r.self_y = sy;  r.self_z = sz;
      r.nbr_x  = nx;  r.nbr_y  = ny;  r.nbr_z  = nz;
      r.nbr_mass     = mass;
      r.rest_density = rest;
      r.gas_const    = gas;
      r.is_self      = self_flag;
      r.last_nbr     = last_flag;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("MISMATCH result %0d %s: expected %h, got %h", rsp_count, name, want, got);
      end
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sdp_pkg::REG_RADIUS_SQ)
         h2_reg = val;
      else
         poly6_reg = val;
   endtask

   task automatic set_kernel(logic [31:0] h2, logic [31:0] p6);
      write_reg(sdp_pkg::REG_RADIUS_SQ, h2);
      write_reg(sdp_pkg::REG_POLY6, p6);
      setting_count++;
   endtask

   // hold until every request is taken and every result is back, then let
   // any out-of-range neighbor still in the datapath finish
   task automatic wait_quiet();
      while (nbr_queue.size() != 0 || req_tvalid || expected_rho.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_density(req_cur);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (nbr_queue.size() != 0) begin
               req_cur = nbr_queue.pop_front();
               req_tdata  <= {req_cur.gas_const, req_cur.rest_density, req_cur.nbr_mass,
                              req_cur.nbr_z, req_cur.nbr_y, req_cur.nbr_x,
                              req_cur.self_z, req_cur.self_y, req_cur.self_x};
               req_tuser  <= req_cur.is_self;
               req_tlast  <= req_cur.last_nbr;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 40) == 0)
                  req_burst = !req_burst;
               req_gap = req_burst ? 0 : $urandom_range(0, 6);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare with the oldest expected result, then stall
   always @(posedge clock) begin
      rho_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rho.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("MISMATCH result %0d arrived with none expected: %h",
                           rsp_count, rsp_tdata);
            end else begin
               want = expected_rho.pop_front();
               check_field("density", want.density, rsp_tdata[31:0]);
               check_field("pressure", want.pressure, rsp_tdata[63:32]);
            end
            if ($urandom_range(0, 40) == 0)
               rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 6);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus: directed phases, then random particle streams
   initial begin
      int          phase, made, n_nbrs, self_slot, shift, j, leftover;
      logic [31:0] sx, sy, sz, ox, oy, oz, span, rest, gas, mass;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset kernel: radius 1.0, constant 1.0
      @(negedge clock);
      // self entry alone still emits, density falls back to rest density
      nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, Q_ONE, 2 * Q_ONE, Q_ONE, 1'b1, 1'b1));
      // co-located neighbor, then one exactly on the radius adding zero
      nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, Q_ONE, 0, Q_ONE, 1'b0, 1'b0));
      nbr_queue.push_back(neighbor(0, 0, 0, Q_ONE, 0, 0, MAX32, 0, Q_ONE, 1'b0, 1'b0));
      // just inside the radius, then a quarter step on every axis
      nbr_queue.push_back(neighbor(0, 0, 0, 32'h0000_FFFF, 0, 0, MAX32, 0, Q_ONE,
                                   1'b0, 1'b0));
      nbr_queue.push_back(neighbor(0, 0, 0, 32'h4000, 32'hFFFF_C000, 32'h4000,
                                   2 * Q_ONE, 0, 3 * Q_ONE, 1'b0, 1'b0));
      // widest position spans, out of range, closing the particle
      nbr_queue.push_back(neighbor(MAX_POS, MIN_POS, MAX32, MIN_POS, MAX_POS, 0,
                                   MAX32, 32'h8000, 3 * Q_ONE, 1'b0, 1'b1));
      // rest density above the sum keeps pressure at zero
      nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, Q_ONE, MAX32, MAX32, 1'b0, 1'b0));
      nbr_queue.push_back(neighbor(5, 5, 5, 5, 5, 5, MAX32, MAX32, MAX32, 1'b1, 1'b1));
      // no neighbor in range
      nbr_queue.push_back(neighbor(0, 0, 0, 2 * Q_ONE, 0, 0, Q_ONE, 3 * Q_ONE, MAX32,
                                   1'b0, 1'b0));
      nbr_queue.push_back(neighbor(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, Q_ONE, 3 * Q_ONE,
                                   MAX32, 1'b0, 1'b1));
      // zero rest density, full gas constant
      nbr_queue.push_back(neighbor(MIN_POS, MIN_POS, MIN_POS, MIN_POS, MIN_POS, MIN_POS,
                                   32'h8000, 0, MAX32, 1'b0, 1'b1));
      wait_quiet();

      // largest kernel: saturate the sum and both outputs
      set_kernel(MAX32, MAX32);
      @(negedge clock);
      nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, MAX32, 0, Q_ONE, 1'b0, 1'b0));
      nbr_queue.push_back(neighbor(7, 7, 7, 7, 7, 7, MAX32, 0, MAX32, 1'b0, 1'b1));
      nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, 0, 5, Q_ONE, 1'b0, 1'b1));
      nbr_queue.push_back(neighbor(MIN_POS, MIN_POS, MIN_POS, MAX_POS, MAX_POS, MAX_POS,
                                   MAX32, 0, MAX32, 1'b0, 1'b1));
      wait_quiet();

      // zero kernel: only a zero distance is in range and it adds nothing
      set_kernel(0, 0);
      @(negedge clock);
      nbr_queue.push_back(neighbor(3, 3, 3, 3, 3, 3, MAX32, 0, MAX32, 1'b0, 1'b0));
      nbr_queue.push_back(neighbor(0, 0, 0, 1, 0, 0, MAX32, Q_ONE, MAX32, 1'b0, 1'b1));
      wait_quiet();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1)
            set_kernel($urandom, $urandom);
         else
            set_kernel($urandom_range(32'h2000, 32'h80000), $urandom_range(0, 32'h40000));
         @(negedge clock);
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            // one particle: self position, its type, then its neighbor list
            n_nbrs    = $urandom_range(1, 8);
            self_slot = $urandom_range(0, n_nbrs);
            shift     = $urandom_range(10, 19);
            span      = 32'd1 << shift;
            sx        = $urandom;
            sy        = $urandom;
            sz        = $urandom;
            rest      = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h80000);
            gas       = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h80000);
            for (j = 0; j < n_nbrs; j++) begin
               if ($urandom_range(0, 11) == 0) begin
                  // noise entry with every field random
                  nbr_queue.push_back(neighbor($urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom, $urandom, $urandom,
                                               $urandom, 1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1))));
               end else begin
                  ox   = (j == self_slot) ? 0 : $urandom_range(0, 2 * span) - span;
                  oy   = (j == self_slot) ? 0 : $urandom_range(0, 2 * span) - span;
                  oz   = (j == self_slot) ? 0 : $urandom_range(0, 2 * span) - span;
                  mass = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h30000);
                  // now and then drop the last flag so particles run together
                  nbr_queue.push_back(neighbor(sx, sy, sz, sx + ox, sy + oy, sz + oz,
                                               mass, rest, gas, j == self_slot,
                                               j == n_nbrs - 1 && $urandom_range(0, 15) != 0));
               end
               made++;
            end
         end
         // close any open particle so the phase ends quiet
         nbr_queue.push_back(neighbor(0, 0, 0, 0, 0, 0, 0, rest, gas, 1'b1, 1'b1));
         wait_quiet();
      end

      leftover = expected_rho.size();
      if (leftover != 0)
         $display("ERROR: %0d expected results never arrived", leftover);
      $display("Checked %0d results from %0d neighbor requests under %0d kernel settings.",
               rsp_count, req_count, setting_count);
      $display("Covered self entries, radius boundary, far and saturating neighbors, %s",
               "random particle streams with gaps and stalls on both sides.");
      if (mismatch_count == 0 && leftover == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Timeout with %0d results still expected", expected_rho.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
